// ===== rtl/i2c_master_bit_engine_defines.svh =====
// Assertion macros for the I2C master bit engine.
// Included by the top level; expects a clock aclk and reset aresetn in scope.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Property checked every cycle outside reset
`define I2CM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property that must hold in the cycle after a trigger
`define I2CM_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
// No dependencies; used by i2cm_seq and i2c_master_bit_engine.
package i2cm_pkg;

    // Command codes
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_WAIT  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_UNIT_TICKS  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // Reset values and sizes
    localparam logic [15:0] UNIT_TICKS_RST  = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
    localparam int          DELAY_BITS_DEF  = 24;
    localparam logic [3:0]  BYTE_BITS       = 4'd8;

    // Sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_FALL, PH_ST_END, PH_SP_RISE, PH_SP_END,
        PH_WR_RISE, PH_WR_FALL, PH_WR_NEXT, PH_RD_RISE, PH_RD_NEXT,
        PH_AK_RISE, PH_AK_END, PH_WA_RISE, PH_WA_POLL
    } phase_t;

    // Hold length requested by a step, in delay units
    typedef enum logic [1:0] {
        HOLD_NONE, HOLD_1, HOLD_2, HOLD_4
    } hold_t;

    // One result word
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rdata;
        logic       ack_error;
    } res_t;

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// I2C master bit engine: one input word is one bus tick, one result word per tick.
// A tick's result is registered in the output register, or in the skid entry while that one holds an unread result.
// Throughput: one tick per cycle; a two-entry output buffer keeps s_ready high
// while one result waits, so input stalls only when both entries are full.
// Reset (aresetn, synchronous, low): idle, SCL and SDA high and driven,
// unit_ticks 100, ack_timeout 250, output buffer empty.
`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd_valid,
    input  logic [2:0]  s_mode,
    input  logic [7:0]  s_wdata,
    input  logic        s_ack_bit,
    input  logic        s_sda_in,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl,
    output logic        m_sda_out,
    output logic        m_sda_drive,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_rdata,
    output logic        m_ack_error
);

    logic [15:0] unit_ticks_reg;
    logic [7:0]  ack_timeout_reg;
    logic        out_valid_reg, skid_valid_reg;
    res_t        out_res_reg, skid_res_reg;
    res_t        seq_res;
    logic        accept, pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg  <= UNIT_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_UNIT_TICKS:  unit_ticks_reg  <= cfg_wdata;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata[7:0];
                default:         unit_ticks_reg  <= unit_ticks_reg;
            endcase
        end
    end

    i2cm_seq #(
        .DELAY_BITS (DELAY_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .cmd_valid   (s_cmd_valid),
        .mode        (s_mode),
        .wdata       (s_wdata),
        .ack_bit     (s_ack_bit),
        .sda_in      (s_sda_in),
        .unit_ticks  (unit_ticks_reg),
        .ack_timeout (ack_timeout_reg),
        .res         (seq_res)
    );

    // Output buffer: main register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                // drain the skid entry into the main register
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (out_valid_reg && !pop) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result words
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_res_reg <= skid_res_reg;
            end
        end else if (accept) begin
            if (out_valid_reg && !pop) begin
                skid_res_reg <= seq_res;
            end else begin
                out_res_reg <= seq_res;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl       = out_res_reg.scl;
    assign m_sda_out   = out_res_reg.sda_out;
    assign m_sda_drive = out_res_reg.sda_drive;
    assign m_busy_res  = out_res_reg.busy_res;
    assign m_done_res  = out_res_reg.done_res;
    assign m_rdata     = out_res_reg.rdata;
    assign m_ack_error = out_res_reg.ack_error;

    // Checks
    `I2CM_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg,
        "skid entry holds a word while the output register is empty")
    `I2CM_ASSERT(a_done_not_busy, !(out_valid_reg && out_res_reg.done_res) || !out_res_reg.busy_res,
        "completion word still reports busy")
    `I2CM_ASSERT_NEXT(a_stall_to_skid, accept && out_valid_reg && !m_ready, skid_valid_reg,
        "word accepted during an output stall was not parked in the skid entry")

endmodule

// ===== rtl/i2cm_seq.sv =====
// Bus sequencer of the I2C master bit engine: phase, line, shift and delay state.
// Depends on i2cm_pkg; advances one tick per step and presents the tick's result.
module i2cm_seq
    import i2cm_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        cmd_valid,
    input  logic [2:0]  mode,
    input  logic [7:0]  wdata,
    input  logic        ack_bit,
    input  logic        sda_in,
    input  logic [15:0] unit_ticks,
    input  logic [7:0]  ack_timeout,
    output res_t        res
);

    localparam int PW = (DELAY_BITS > 18) ? DELAY_BITS : 18;
    localparam logic [PW-1:0] DMAX = PW'((64'd1 << DELAY_BITS) - 64'd1);

    phase_t                phase_reg, phase_next;
    logic [3:0]            bit_idx_reg, bit_idx_next;
    logic [7:0]            shifter_reg, shifter_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic [7:0]            poll_reg, poll_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  drv_reg, drv_next;
    logic [7:0]            rdata_reg, rdata_next;
    logic                  err_reg, err_next;
    logic                  ack_latch_reg, ack_latch_next;

    logic                  idle, counting, fire, done_c;
    hold_t                 hold_sel;
    logic [1:0]            hold_shift;
    logic [PW-1:0]         prod;
    logic [DELAY_BITS-1:0] hold_val;

    // Tick classification: idle, still holding, or running the due step
    assign idle     = (phase_reg == PH_IDLE);
    assign counting = !idle && (delay_reg > DELAY_BITS'(1));
    assign fire     = !idle && !counting;

    // Hold length: units times unit_ticks, saturated to the counter
    always_comb begin
        unique case (hold_sel)
            HOLD_2:  hold_shift = 2'd1;
            HOLD_4:  hold_shift = 2'd2;
            default: hold_shift = 2'd0;
        endcase
    end
    assign prod     = PW'(unit_ticks) << hold_shift;
    assign hold_val = (prod > DMAX) ? DMAX[DELAY_BITS-1:0] : prod[DELAY_BITS-1:0];

    // Next phase and completion
    always_comb begin
        phase_next = phase_reg;
        done_c     = 1'b0;
        if (idle) begin
            if (cmd_valid) begin
                unique case (mode)
                    MODE_START: phase_next = PH_ST_FALL;
                    MODE_STOP:  phase_next = PH_SP_RISE;
                    MODE_WRITE: phase_next = PH_WR_RISE;
                    MODE_READ:  phase_next = PH_RD_RISE;
                    MODE_WAIT:  phase_next = PH_WA_RISE;
                    default:    phase_next = PH_IDLE;
                endcase
            end
        end else if (fire) begin
            unique case (phase_reg)
                PH_ST_FALL: phase_next = PH_ST_END;
                PH_ST_END: begin
                    phase_next = PH_IDLE;
                    done_c     = 1'b1;
                end
                PH_SP_RISE: phase_next = PH_SP_END;
                PH_SP_END: begin
                    phase_next = PH_IDLE;
                    done_c     = 1'b1;
                end
                PH_WR_RISE: phase_next = PH_WR_FALL;
                PH_WR_FALL: phase_next = PH_WR_NEXT;
                PH_WR_NEXT: begin
                    if (bit_idx_reg >= BYTE_BITS) begin
                        phase_next = PH_IDLE;
                        done_c     = 1'b1;
                    end else begin
                        phase_next = PH_WR_RISE;
                    end
                end
                PH_RD_RISE: phase_next = PH_RD_NEXT;
                PH_RD_NEXT: begin
                    phase_next = (bit_idx_reg < BYTE_BITS) ? PH_RD_RISE : PH_AK_RISE;
                end
                PH_AK_RISE: phase_next = PH_AK_END;
                PH_AK_END: begin
                    phase_next = PH_IDLE;
                    done_c     = 1'b1;
                end
                PH_WA_RISE: phase_next = PH_WA_POLL;
                PH_WA_POLL: begin
                    if (!sda_in) begin
                        phase_next = PH_IDLE;
                        done_c     = 1'b1;
                    end else if (poll_reg >= ack_timeout) begin
                        phase_next = PH_SP_RISE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Line, shift, counter and flag updates
    always_comb begin
        bit_idx_next   = bit_idx_reg;
        shifter_next   = shifter_reg;
        poll_next      = poll_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drv_next       = drv_reg;
        rdata_next     = rdata_reg;
        err_next       = err_reg;
        ack_latch_next = ack_latch_reg;
        hold_sel       = HOLD_NONE;
        if (idle) begin
            if (cmd_valid) begin
                unique case (mode)
                    MODE_START: begin
                        drv_next = 1'b1;
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                        hold_sel = HOLD_4;
                    end
                    MODE_STOP: begin
                        drv_next = 1'b1;
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                        hold_sel = HOLD_4;
                    end
                    MODE_WRITE: begin
                        drv_next     = 1'b1;
                        scl_next     = 1'b0;
                        bit_idx_next = '0;
                        sda_next     = wdata[7];
                        shifter_next = {wdata[6:0], 1'b0};
                        hold_sel     = HOLD_2;
                    end
                    MODE_READ: begin
                        drv_next       = 1'b0;
                        ack_latch_next = ack_bit;
                        shifter_next   = '0;
                        bit_idx_next   = '0;
                        scl_next       = 1'b0;
                        hold_sel       = HOLD_2;
                    end
                    MODE_WAIT: begin
                        drv_next  = 1'b0;
                        sda_next  = 1'b1;
                        poll_next = '0;
                        err_next  = 1'b0;
                        hold_sel  = HOLD_1;
                    end
                    default: begin
                        hold_sel = HOLD_NONE;
                    end
                endcase
            end
        end else if (fire) begin
            unique case (phase_reg)
                PH_ST_FALL: begin
                    sda_next = 1'b0;
                    hold_sel = HOLD_4;
                end
                PH_ST_END: scl_next = 1'b0;
                PH_SP_RISE: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    hold_sel = HOLD_4;
                end
                PH_WR_RISE: begin
                    scl_next = 1'b1;
                    hold_sel = HOLD_2;
                end
                PH_WR_FALL: begin
                    scl_next     = 1'b0;
                    bit_idx_next = bit_idx_reg + 4'd1;
                    hold_sel     = HOLD_2;
                end
                PH_WR_NEXT: begin
                    if (bit_idx_reg < BYTE_BITS) begin
                        sda_next     = shifter_reg[7];
                        shifter_next = {shifter_reg[6:0], 1'b0};
                        hold_sel     = HOLD_2;
                    end
                end
                PH_RD_RISE: begin
                    scl_next     = 1'b1;
                    shifter_next = {shifter_reg[6:0], sda_in};
                    bit_idx_next = bit_idx_reg + 4'd1;
                    hold_sel     = HOLD_1;
                end
                PH_RD_NEXT: begin
                    scl_next = 1'b0;
                    hold_sel = HOLD_2;
                    if (bit_idx_reg >= BYTE_BITS) begin
                        // byte complete: latch it and drive the ACK choice
                        rdata_next = shifter_reg;
                        drv_next   = 1'b1;
                        sda_next   = !ack_latch_reg;
                    end
                end
                PH_AK_RISE: begin
                    scl_next = 1'b1;
                    hold_sel = HOLD_2;
                end
                PH_AK_END: scl_next = 1'b0;
                PH_WA_RISE: begin
                    scl_next = 1'b1;
                    hold_sel = HOLD_1;
                end
                PH_WA_POLL: begin
                    if (!sda_in) begin
                        scl_next = 1'b0;
                    end else if (poll_reg >= ack_timeout) begin
                        // timeout: flag and fall into the stop sequence
                        err_next = 1'b1;
                        drv_next = 1'b1;
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                        hold_sel = HOLD_4;
                    end else begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                default: hold_sel = HOLD_NONE;
            endcase
        end
    end

    // Delay counter: load a new hold, count down, or clear on the step tick
    always_comb begin
        if (hold_sel != HOLD_NONE) begin
            delay_next = hold_val;
        end else if (counting) begin
            delay_next = delay_reg - DELAY_BITS'(1);
        end else if (fire) begin
            delay_next = '0;
        end else begin
            delay_next = delay_reg;
        end
    end

    // Result of this tick: state after the update
    always_comb begin
        res.scl       = scl_next;
        res.sda_out   = sda_next;
        res.sda_drive = drv_next;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done_c;
        res.rdata     = rdata_next;
        res.ack_error = err_next;
    end

    // State registers, advanced once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_idx_reg   <= '0;
            shifter_reg   <= '0;
            delay_reg     <= '0;
            poll_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drv_reg       <= 1'b1;
            rdata_reg     <= '0;
            err_reg       <= 1'b0;
            ack_latch_reg <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            bit_idx_reg   <= bit_idx_next;
            shifter_reg   <= shifter_next;
            delay_reg     <= delay_next;
            poll_reg      <= poll_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drv_reg       <= drv_next;
            rdata_reg     <= rdata_next;
            err_reg       <= err_next;
            ack_latch_reg <= ack_latch_next;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for i2c_master_bit_engine: drives bus ticks and compares line words.
// Depends on i2cm_pkg and the engine RTL; holds its own tick-level model of the engine.
module tb;
    import i2cm_pkg::*;

    localparam bit [31:0]  HOLD_MAX    = (32'd1 << DELAY_BITS_DEF) - 1;
    localparam logic [2:0] MODE_BAD_LO = 3'd5;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;
    localparam int         STUCK_LIMIT = 5000;
    localparam int         END_SETTLE  = 16;
    localparam int         MAX_REPORTS = 100;

    // One bus tick offered to the engine
    typedef struct {
        bit       cmd_valid;
        bit [2:0] mode;
        bit [7:0] wdata;
        bit       ack_bit;
        bit       sda_in;
    } tick_t;

    // How the slave drives SDA during the ticks of a command
    typedef enum {SDA_RANDOM, SDA_LOW, SDA_HIGH, SDA_LATE} sda_policy_t;

    // Engine model and store of expected line words
    class line_scoreboard;
        bit [15:0] unit_ticks;
        bit [7:0]  ack_limit;
        phase_t    ph;
        bit [3:0]  bit_cnt;
        bit [7:0]  shift_reg;
        bit [31:0] hold_left;
        bit [7:0]  polls;
        bit        scl_q;
        bit        sda_q;
        bit        drv_q;
        bit [7:0]  rx_byte;
        bit        timed_out;
        bit        ack_sel;
        res_t      expected_lines[$];
        int        errors;

        function new();
            unit_ticks = UNIT_TICKS_RST;
            ack_limit  = ACK_TIMEOUT_RST;
            ph         = PH_IDLE;
            bit_cnt    = '0;
            shift_reg  = '0;
            hold_left  = '0;
            polls      = '0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            drv_q      = 1'b1;
            rx_byte    = '0;
            timed_out  = 1'b0;
            ack_sel    = 1'b0;
            errors     = 0;
        endfunction

        function void set_cfg(bit idx, bit [15:0] val);
            if (idx == CFG_UNIT_TICKS) begin
                unit_ticks = val;
            end else begin
                ack_limit = val[7:0];
            end
        endfunction

        function bit busy();
            return ph != PH_IDLE;
        endfunction

        function bit pending();
            return expected_lines.size() != 0;
        endfunction

        // Load the hold counter, saturating at the counter width
        function void hold_for(int unsigned units);
            bit [31:0] span;
            span = units * unit_ticks;
            hold_left = (span > HOLD_MAX) ? HOLD_MAX : span;
        endfunction

        function void put_bit();
            sda_q = shift_reg[7];
            shift_reg = shift_reg << 1;
            hold_for(2);
            ph = PH_WR_RISE;
        endfunction

        function void read_low();
            scl_q = 1'b0;
            hold_for(2);
            ph = PH_RD_RISE;
        endfunction

        function void stop_begin();
            drv_q = 1'b1;
            scl_q = 1'b0;
            sda_q = 1'b0;
            hold_for(4);
            ph = PH_SP_RISE;
        endfunction

        // Run the due step of the active command; return 1 on completion
        function bit advance(bit sda);
            case (ph)
                PH_ST_FALL: begin
                    sda_q = 1'b0;
                    hold_for(4);
                    ph = PH_ST_END;
                end
                PH_ST_END: begin
                    scl_q = 1'b0;
                    return 1'b1;
                end
                PH_SP_RISE: begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    hold_for(4);
                    ph = PH_SP_END;
                end
                PH_SP_END: return 1'b1;
                PH_WR_RISE: begin
                    scl_q = 1'b1;
                    hold_for(2);
                    ph = PH_WR_FALL;
                end
                PH_WR_FALL: begin
                    scl_q = 1'b0;
                    bit_cnt = bit_cnt + 1'b1;
                    hold_for(2);
                    ph = PH_WR_NEXT;
                end
                PH_WR_NEXT: begin
                    if (bit_cnt >= BYTE_BITS) return 1'b1;
                    put_bit();
                end
                PH_RD_RISE: begin
                    scl_q = 1'b1;
                    shift_reg = {shift_reg[6:0], sda};
                    bit_cnt = bit_cnt + 1'b1;
                    hold_for(1);
                    ph = PH_RD_NEXT;
                end
                PH_RD_NEXT: begin
                    if (bit_cnt < BYTE_BITS) begin
                        read_low();
                    end else begin
                        rx_byte = shift_reg;
                        scl_q = 1'b0;
                        drv_q = 1'b1;
                        sda_q = !ack_sel;
                        hold_for(2);
                        ph = PH_AK_RISE;
                    end
                end
                PH_AK_RISE: begin
                    scl_q = 1'b1;
                    hold_for(2);
                    ph = PH_AK_END;
                end
                PH_AK_END: begin
                    scl_q = 1'b0;
                    return 1'b1;
                end
                PH_WA_RISE: begin
                    scl_q = 1'b1;
                    hold_for(1);
                    ph = PH_WA_POLL;
                end
                PH_WA_POLL: begin
                    if (!sda) begin
                        scl_q = 1'b0;
                        return 1'b1;
                    end
                    if (polls >= ack_limit) begin
                        timed_out = 1'b1;
                        stop_begin();
                    end else begin
                        polls = polls + 1'b1;
                        hold_left = '0;
                    end
                end
                default: ph = PH_IDLE;
            endcase
            return 1'b0;
        endfunction

        // Latch a new command while idle; unknown modes leave the engine idle
        function void start_cmd(tick_t t);
            case (t.mode)
                MODE_START: begin
                    drv_q = 1'b1;
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    hold_for(4);
                    ph = PH_ST_FALL;
                end
                MODE_STOP: stop_begin();
                MODE_WRITE: begin
                    drv_q = 1'b1;
                    scl_q = 1'b0;
                    shift_reg = t.wdata;
                    bit_cnt = '0;
                    put_bit();
                end
                MODE_READ: begin
                    drv_q = 1'b0;
                    ack_sel = t.ack_bit;
                    shift_reg = '0;
                    bit_cnt = '0;
                    read_low();
                end
                MODE_WAIT: begin
                    drv_q = 1'b0;
                    sda_q = 1'b1;
                    polls = '0;
                    timed_out = 1'b0;
                    hold_for(1);
                    ph = PH_WA_RISE;
                end
                default: ;
            endcase
        endfunction

        // Step the model by one accepted tick and queue the line word it yields
        function void log_tick(tick_t t);
            bit   done;
            res_t word;
            done = 1'b0;
            if (ph == PH_IDLE) begin
                if (t.cmd_valid) start_cmd(t);
            end else if (hold_left > 1) begin
                hold_left = hold_left - 1;
            end else begin
                hold_left = '0;
                done = advance(t.sda_in);
                if (done) ph = PH_IDLE;
            end
            word.scl       = scl_q;
            word.sda_out   = sda_q;
            word.sda_drive = drv_q;
            word.busy_res  = (ph != PH_IDLE);
            word.done_res  = done;
            word.rdata     = rx_byte;
            word.ack_error = timed_out;
            expected_lines.push_back(word);
        endfunction

        function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (exp_v !== got_v) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h got %0h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Compare one accepted line word with the oldest expectation
        function void check_lines(res_t got);
            res_t exp_w;
            if (expected_lines.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: line word with nothing expected, expected none got %p",
                             $time, got);
                errors++;
                return;
            end
            exp_w = expected_lines.pop_front();
            cmp_field("scl", 8'(exp_w.scl), 8'(got.scl));
            cmp_field("sda_out", 8'(exp_w.sda_out), 8'(got.sda_out));
            cmp_field("sda_drive", 8'(exp_w.sda_drive), 8'(got.sda_drive));
            cmp_field("busy_res", 8'(exp_w.busy_res), 8'(got.busy_res));
            cmp_field("done_res", 8'(exp_w.done_res), 8'(got.done_res));
            cmp_field("rdata", exp_w.rdata, got.rdata);
            cmp_field("ack_error", 8'(exp_w.ack_error), 8'(got.ack_error));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = CFG_UNIT_TICKS;
    logic [15:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_cmd_valid = 1'b0;
    logic [2:0]  s_mode      = MODE_START;
    logic [7:0]  s_wdata     = '0;
    logic        s_ack_bit   = 1'b0;
    logic        s_sda_in    = 1'b1;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_scl;
    logic        m_sda_out;
    logic        m_sda_drive;
    logic        m_busy_res;
    logic        m_done_res;
    logic [7:0]  m_rdata;
    logic        m_ack_error;

    line_scoreboard lines_sb;
    int             src_idle_pct;
    int             dst_stall_pct;
    sda_policy_t    sda_policy;
    int             ticks_sent;
    int             stuck_cycles;

    i2c_master_bit_engine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd_valid (s_cmd_valid),
        .s_mode      (s_mode),
        .s_wdata     (s_wdata),
        .s_ack_bit   (s_ack_bit),
        .s_sda_in    (s_sda_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl       (m_scl),
        .m_sda_out   (m_sda_out),
        .m_sda_drive (m_sda_drive),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_rdata     (m_rdata),
        .m_ack_error (m_ack_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Tick offered while a command runs: random command noise, SDA per policy
    function automatic tick_t busy_tick();
        tick_t t;
        t.cmd_valid = 1'($urandom_range(0, 1));
        t.mode      = 3'($urandom_range(MODE_START, MODE_BAD_HI));
        t.wdata     = 8'($urandom);
        t.ack_bit   = 1'($urandom_range(0, 1));
        case (sda_policy)
            SDA_LOW:  t.sda_in = 1'b0;
            SDA_HIGH: t.sda_in = 1'b1;
            SDA_LATE: t.sda_in = ($urandom_range(0, 7) != 0);
            default:  t.sda_in = 1'($urandom_range(0, 1));
        endcase
        return t;
    endfunction

    // Tick offered while idle that must not start anything
    function automatic tick_t idle_tick();
        tick_t t;
        t = busy_tick();
        if (t.cmd_valid) t.mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
        return t;
    endfunction

    // Offer one tick word, hold it until accepted, then step the model
    task automatic send_tick(input tick_t t);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd_valid <= t.cmd_valid;
        s_mode      <= t.mode;
        s_wdata     <= t.wdata;
        s_ack_bit   <= t.ack_bit;
        s_sda_in    <= t.sda_in;
        do @(posedge aclk); while (!s_ready);
        lines_sb.log_tick(t);
        ticks_sent++;
    endtask

    // Advance the engine until the running command has finished
    task automatic settle();
        while (lines_sb.busy()) send_tick(busy_tick());
    endtask

    // Hold off the sender until every expected line word has arrived
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (lines_sb.pending());
    endtask

    // Finish the command, drain, then write both registers
    task automatic write_cfg(input bit [15:0] unit_val, input bit [7:0] tmo_val);
        settle();
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNIT_TICKS;
        cfg_wdata <= unit_val;
        @(posedge aclk);
        lines_sb.set_cfg(CFG_UNIT_TICKS, unit_val);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_wdata <= {8'd0, tmo_val};
        @(posedge aclk);
        lines_sb.set_cfg(CFG_ACK_TIMEOUT, {8'd0, tmo_val});
        cfg_we <= 1'b0;
    endtask

    // Wait for idle, maybe pass a few ignored ticks, then offer the command
    task automatic issue(input logic [2:0] mode, input logic [7:0] byte_val,
                         input bit ack, input sda_policy_t pol);
        tick_t t;
        settle();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_tick(idle_tick());
        sda_policy  = pol;
        t           = busy_tick();
        t.cmd_valid = 1'b1;
        t.mode      = mode;
        t.wdata     = byte_val;
        t.ack_bit   = ack;
        send_tick(t);
    endtask

    function automatic sda_policy_t pick_ack_policy();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return SDA_HIGH;
        if (r < 4) return SDA_LATE;
        return SDA_LOW;
    endfunction

    // Start, one to three bytes, each written or read, usually a stop
    task automatic run_transfer();
        issue(MODE_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) < 3) begin
                issue(MODE_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
                issue(MODE_WAIT, 8'($urandom), 1'($urandom_range(0, 1)), pick_ack_policy());
            end else begin
                issue(MODE_READ, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
            end
        end
        if ($urandom_range(0, 4) != 0)
            issue(MODE_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM);
    endtask

    // Random traffic under one register setting; pause the sender once
    task automatic run_random(input bit [15:0] unit_val, input bit [7:0] tmo_val,
                              input int budget);
        int  first;
        bit  paused;
        write_cfg(unit_val, tmo_val);
        first  = ticks_sent;
        paused = 1'b0;
        while (ticks_sent - first < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                issue(3'($urandom_range(MODE_START, MODE_BAD_HI)), 8'($urandom),
                      1'($urandom_range(0, 1)), sda_policy_t'($urandom_range(0, 3)));
            end else begin
                run_transfer();
            end
            if (!paused) begin
                drain();
                paused = 1'b1;
            end
        end
        settle();
    endtask

    // Check line words, drive receiver stalls, watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                lines_sb.check_lines('{m_scl, m_sda_out, m_sda_drive, m_busy_res,
                                       m_done_res, m_rdata, m_ack_error});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        m_ready <= ($urandom_range(0, 99) >= dst_stall_pct);
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("i2c_master_bit_engine verification failed");
            $finish;
        end
    end

    initial begin
        tick_t t;
        lines_sb      = new();
        src_idle_pct  = 11;
        dst_stall_pct = 68;
        sda_policy    = SDA_RANDOM;
        ticks_sent    = 0;
        stuck_cycles  = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: an ACK wait answered at the first poll
        issue(MODE_WAIT, 8'h00, 1'b0, SDA_LOW);

        // Zero unit and zero timeout: unknown modes, edge bytes, both ACK outcomes
        write_cfg(16'd0, 8'd0);
        for (int m = MODE_BAD_LO; m <= MODE_BAD_HI; m++) begin
            t           = idle_tick();
            t.cmd_valid = 1'b1;
            t.mode      = 3'(m);
            send_tick(t);
        end
        issue(MODE_START, 8'h00, 1'b0, SDA_RANDOM);
        issue(MODE_WRITE, 8'h00, 1'b0, SDA_RANDOM);
        issue(MODE_WAIT, 8'h00, 1'b0, SDA_HIGH);
        issue(MODE_WAIT, 8'h00, 1'b0, SDA_LOW);
        issue(MODE_WRITE, 8'hFF, 1'b1, SDA_RANDOM);
        issue(MODE_WAIT, 8'hFF, 1'b1, SDA_LATE);
        issue(MODE_READ, 8'h00, 1'b1, SDA_RANDOM);
        issue(MODE_READ, 8'h00, 1'b0, SDA_HIGH);
        issue(MODE_READ, 8'hFF, 1'b1, SDA_LOW);
        issue(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);

        // Longest timeout with SDA never pulled low
        write_cfg(16'd1, 8'd255);
        issue(MODE_WAIT, 8'h00, 1'b0, SDA_HIGH);
        issue(MODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
        issue(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM);

        run_random(16'd1, 8'd3, 80);

        src_idle_pct  = 68;
        dst_stall_pct = 11;
        run_random(16'd0, 8'd1, 60);
        run_random(16'd2, 8'd255, 50);

        src_idle_pct  = 0;
        dst_stall_pct = 0;
        run_random(16'd3, 8'd0, 50);

        drain();
        repeat (END_SETTLE) @(posedge aclk);
        if (lines_sb.errors == 0 && !lines_sb.pending()) begin
            $display("i2c_master_bit_engine verification clean");
        end else begin
            $display("i2c_master_bit_engine verification failed");
        end
        $finish;
    end

endmodule
